FILE: hw/rtl/lrgg_pkg.sv
`timescale 1ns / 1ps

package lrgg_pkg;

    localparam int CHAN_W    = 8;
    localparam int NUM_LANES = 4;
    localparam int COLOR_W   = CHAN_W * NUM_LANES;
    localparam int COORD_W   = 16;
    localparam int DIM_W     = COORD_W + 1;
    // numerator s*(span-j) + e*j stays below 256*span
    localparam int NUM_W     = CHAN_W + COORD_W;
    localparam int STEP_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] MAX_DIM      = DIM_W'(65536);
    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(800);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(600);
    localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(CHAN_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_COLOR  = 2'd0,
        CFG_END_COLOR    = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } cfg_index_t;

    // clamped configuration as seen by the datapath
    typedef struct packed {
        logic [COLOR_W-1:0] start_color;
        logic [COLOR_W-1:0] end_color;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COORD_W-1:0] divisor;  // width-1, or 1 for a one-pixel row
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic load_num;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/linear_rgba_gradient_generator.sv
`timescale 1ns / 1ps

// horizontal rgba gradient raster source
// - s_ channel: one word per pixel request; s_restart=1 restarts the frame at
//   pixel (0,0), s_restart=0 steps to the next pixel in row-major order
// - m_ channel: one word per request with the four interpolated channels,
//   column, row and end-of-row / end-of-frame flags
// - cfg channel: cfg_index selects start color, end color, width or height;
//   cfg_ready is always high; write only while no pixel is in flight
// - each channel is floor((s*(w-1-j) + e*j) / (w-1)); a one-pixel row gives
//   the start color; width/height of zero act as one, above 65536 as 65536
// - a request runs through the multiply, divide and load states: the
//   multiply state forms the numerators, the divide state runs the
//   restoring divider (one quotient bit per cycle, four lanes in parallel),
//   and the load state writes the output register once it is free
// - s_ready is high only in the idle state: one request in work at a time
// - the output register frees s_ready for the next word while the last
//   result waits; if m_ready stays low, the next result holds in the
//   datapath and s_ready stays low until the output register drains
// - reset: synchronous, active low; clears position to (0,0), restores the
//   800x600 default size and black endpoints, drops m_valid

module linear_rgba_gradient_generator
    import lrgg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,

    // pixel requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,

    // pixels
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CHAN_W-1:0]    m_red,
    output logic [CHAN_W-1:0]    m_green,
    output logic [CHAN_W-1:0]    m_blue,
    output logic [CHAN_W-1:0]    m_alpha,
    output logic [COORD_W-1:0]   m_column,
    output logic [COORD_W-1:0]   m_row,
    output logic                 m_end_of_row,
    output logic                 m_end_of_frame
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // register file with clamping of the frame size
    lrgg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: accept, multiply, divide, hand off to output register
    lrgg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // position counters, per-channel multiply and divide, output register
    lrgg_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule

FILE: hw/rtl/lrgg_cfg_regs.sv
`timescale 1ns / 1ps

module lrgg_cfg_regs
    import lrgg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,
    output cfg_t                 cfg
);

    logic [COLOR_W-1:0] start_reg;
    logic [COLOR_W-1:0] end_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [DIM_W-1:0]   width_clamped;
    logic [DIM_W-1:0]   height_clamped;
    logic [DIM_W-1:0]   span;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            end_reg    <= '0;
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_COLOR:  start_reg  <= cfg_data;
                CFG_END_COLOR:    end_reg    <= cfg_data;
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // zero reads as one, anything above the maximum as the maximum
    always_comb begin
        width_clamped  = width_reg;
        height_clamped = height_reg;
        if (width_reg == '0)
            width_clamped = DIM_W'(1);
        else if (width_reg > MAX_DIM)
            width_clamped = MAX_DIM;
        if (height_reg == '0)
            height_clamped = DIM_W'(1);
        else if (height_reg > MAX_DIM)
            height_clamped = MAX_DIM;
        span = width_clamped - DIM_W'(1);
    end

    always_comb begin
        cfg.start_color = start_reg;
        cfg.end_color   = end_reg;
        cfg.width       = width_clamped;
        cfg.height      = height_clamped;
        // one-pixel row: divide s*1 by 1 to get the start color
        cfg.divisor     = (span == '0) ? COORD_W'(1) : span[COORD_W-1:0];
    end

endmodule

FILE: hw/rtl/lrgg_ctrl.sv
`timescale 1ns / 1ps

module lrgg_ctrl
    import lrgg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_LOAD
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.accept   = 1'b0;
        cmd.load_num = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.load_num = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                    state_next = S_LOAD;
            end
            S_LOAD: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: hw/rtl/lrgg_datapath.sv
`timescale 1ns / 1ps

module lrgg_datapath
    import lrgg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAN_W-1:0]  m_red,
    output logic [CHAN_W-1:0]  m_green,
    output logic [CHAN_W-1:0]  m_blue,
    output logic [CHAN_W-1:0]  m_alpha,
    output logic [COORD_W-1:0] m_column,
    output logic [COORD_W-1:0] m_row,
    output logic               m_end_of_row,
    output logic               m_end_of_frame
);

    // raster position
    logic [COORD_W-1:0] next_col_reg;
    logic [COORD_W-1:0] next_row_reg;
    logic [COORD_W-1:0] cur_col_reg;
    logic [COORD_W-1:0] cur_row_reg;
    logic               cur_eor_reg;
    logic               cur_eof_reg;

    logic [DIM_W-1:0]   col_a;
    logic [DIM_W-1:0]   row_a;
    logic [DIM_W-1:0]   col_b;
    logic [DIM_W-1:0]   row_b;
    logic [DIM_W-1:0]   row_c;
    logic               eor;
    logic               eof;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_next;

    always_comb begin
        col_a = s_restart ? '0 : {1'b0, next_col_reg};
        row_a = s_restart ? '0 : {1'b0, next_row_reg};
        // position left outside a shrunk frame wraps to the next row
        if (col_a >= cfg.width) begin
            col_b = '0;
            row_b = row_a + DIM_W'(1);
        end else begin
            col_b = col_a;
            row_b = row_a;
        end
        row_c = (row_b >= cfg.height) ? '0 : row_b;
        eor   = (col_b == cfg.width - DIM_W'(1));
        eof   = eor && (row_c == cfg.height - DIM_W'(1));
        if (eor) begin
            col_next = '0;
            row_next = eof ? '0 : COORD_W'(row_c + DIM_W'(1));
        end else begin
            col_next = COORD_W'(col_b + DIM_W'(1));
            row_next = row_c[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_col_reg <= '0;
            next_row_reg <= '0;
        end else if (cmd.accept) begin
            next_col_reg <= col_next;
            next_row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cur_col_reg <= col_b[COORD_W-1:0];
            cur_row_reg <= row_c[COORD_W-1:0];
            cur_eor_reg <= eor;
            cur_eof_reg <= eof;
        end
    end

    // divisor shifted down one bit per quotient bit
    logic [NUM_W-1:0] dvs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_num)
            dvs_reg <= {1'b0, cfg.divisor, {(CHAN_W-1){1'b0}}};
        else if (cmd.div_step)
            dvs_reg <= dvs_reg >> 1;
    end

    logic [CHAN_W-1:0] quot [NUM_LANES];

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        logic [CHAN_W-1:0]  s_chan;
        logic [CHAN_W-1:0]  e_chan;
        logic [COORD_W-1:0] weight_s;
        logic [NUM_W:0]     num;
        logic [NUM_W:0]     trial;
        logic [NUM_W-1:0]   rem_reg;
        logic [CHAN_W-1:0]  quot_reg;

        assign s_chan   = cfg.start_color[COLOR_W-1-CHAN_W*l -: CHAN_W];
        assign e_chan   = cfg.end_color[COLOR_W-1-CHAN_W*l -: CHAN_W];
        assign weight_s = cfg.divisor - cur_col_reg;
        assign num      = ({{(NUM_W+1-CHAN_W){1'b0}}, s_chan}
                           * {{(NUM_W+1-COORD_W){1'b0}}, weight_s})
                        + ({{(NUM_W+1-CHAN_W){1'b0}}, e_chan}
                           * {{(NUM_W+1-COORD_W){1'b0}}, cur_col_reg});
        assign trial    = {1'b0, rem_reg} - {1'b0, dvs_reg};

        // restoring division, quotient known to fit a byte
        always_ff @(posedge aclk) begin
            if (cmd.load_num) begin
                rem_reg  <= num[NUM_W-1:0];
                quot_reg <= '0;
            end else if (cmd.div_step) begin
                if (!trial[NUM_W])
                    rem_reg <= trial[NUM_W-1:0];
                quot_reg <= {quot_reg[CHAN_W-2:0], ~trial[NUM_W]};
            end
        end

        assign quot[l] = quot_reg;
    end

    // output register
    logic               out_valid_reg;
    logic [CHAN_W-1:0]  red_reg;
    logic [CHAN_W-1:0]  green_reg;
    logic [CHAN_W-1:0]  blue_reg;
    logic [CHAN_W-1:0]  alpha_reg;
    logic [COORD_W-1:0] column_reg;
    logic [COORD_W-1:0] row_reg;
    logic               eor_reg;
    logic               eof_reg;

    assign status.out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            red_reg    <= quot[0];
            green_reg  <= quot[1];
            blue_reg   <= quot[2];
            alpha_reg  <= quot[3];
            column_reg <= cur_col_reg;
            row_reg    <= cur_row_reg;
            eor_reg    <= cur_eor_reg;
            eof_reg    <= cur_eof_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_alpha        = alpha_reg;
    assign m_column       = column_reg;
    assign m_row          = row_reg;
    assign m_end_of_row   = eor_reg;
    assign m_end_of_frame = eof_reg;

endmodule

FILE: hw/rtl/lrgg_checker.sv
`timescale 1ns / 1ps

module lrgg_checker
    import lrgg_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [CHAN_W-1:0]    m_red,
    input logic [COORD_W-1:0]   m_column,
    input logic [COORD_W-1:0]   m_row,
    input logic                 m_end_of_row,
    input logic                 m_end_of_frame
);

    // the last pixel of a frame is also the last of its row
    a_eof_implies_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_end_of_frame || m_end_of_row))
        else $error("end of frame without end of row");

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous still in work");

    // output drops out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_red) && $stable(m_column)
                                   && $stable(m_row)))
        else $error("stalled result changed");

endmodule

bind linear_rgba_gradient_generator lrgg_checker u_lrgg_checker (.*);
